/* sv/prb_pkg.sv */
// Shared types and codes for the packet reorder buffer.
package prb_pkg;

    localparam int SEQ_W  = 16;
    localparam int OFF_W  = 10;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 11;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_DUP   = 2'd1;
    localparam status_t ST_RANGE = 2'd2;
    localparam status_t ST_EMPTY = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

endpackage

/* sv/packet_reorder_buffer_unit.sv */
// Packet reorder buffer: slot store, in-order drain and sliding sequence window.
// Each word passes five steps: accept, look-up read, execute/write-back, head length
// re-read, result load; the single read port of the length and byte memories sets them.
// A result is held for out_ready; the next word is taken only after the result load.
// Reset (async, rst_n low) empties every slot, zeroes head pointers, window base = 1;
// an initial_sequence write restarts the window the same way at the written value.
module packet_reorder_buffer_unit #(
    parameter int SLOTS      = 64,
    parameter int SLOT_BYTES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_write,
    input  logic [prb_pkg::SEQ_W-1:0]     initial_sequence,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [prb_pkg::SEQ_W-1:0]     seq,
    input  logic [prb_pkg::OFF_W-1:0]     byte_offset,
    input  logic [prb_pkg::BYTE_W-1:0]    byte_value,
    input  logic                          end_of_packet,
    // output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output prb_pkg::status_t              status,
    output logic [prb_pkg::BYTE_W-1:0]    read_byte,
    output logic                          read_valid,
    output logic                          packet_end,
    output logic [prb_pkg::LEN_W-1:0]     head_length
);
    import prb_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ADDR_W = $clog2(SLOTS * SLOT_BYTES);
    localparam logic [SLOT_W:0]   SLOTS_EXT = SLOTS[SLOT_W:0];
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_HLEN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [SEQ_W-1:0]  window_base_reg, window_base_next;
    logic [OFF_W-1:0]  head_offset_reg, head_offset_next;
    logic [SLOT_W-1:0] head_slot_reg, head_slot_next;
    logic [SLOTS-1:0]  filled_reg, filled_next;
    logic              out_valid_reg;

    // captured word and look-up results (payload, no reset)
    logic              op_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [BYTE_W-1:0] val_reg;
    logic              eop_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              in_range_reg;
    logic [ADDR_W-1:0] wr_addr_reg;

    // per-word result, then output register
    status_t           res_status_reg, res_status_next;
    logic [BYTE_W-1:0] res_byte_reg, res_byte_next;
    logic              res_rvalid_reg, res_rvalid_next;
    logic              res_pend_reg, res_pend_next;
    status_t           status_reg;
    logic [BYTE_W-1:0] read_byte_reg;
    logic              read_valid_reg;
    logic              packet_end_reg;
    logic [LEN_W-1:0]  head_length_reg;

    // memories: per-slot length and the byte store
    logic [LEN_W-1:0]  len_mem [SLOTS];
    logic [BYTE_W-1:0] store_mem [SLOTS * SLOT_BYTES];
    logic [LEN_W-1:0]  len_q;
    logic [BYTE_W-1:0] store_q;
    logic [ADDR_W-1:0] rd_addr;
    logic              len_we, store_we;

    // window look-up
    logic [SEQ_W-1:0]  delta;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] slot_calc;
    logic              in_range_calc;
    logic [LEN_W-1:0]  pos_inc;

    logic accept_in, load_out;

    assign accept_in = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign load_out  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    assign delta         = seq_reg - window_base_reg;
    assign slot_sum      = {1'b0, head_slot_reg} + {1'b0, delta[SLOT_W-1:0]};
    assign slot_calc     = (slot_sum >= SLOTS_EXT) ? SLOT_W'(slot_sum - SLOTS_EXT)
                                                   : slot_sum[SLOT_W-1:0];
    assign in_range_calc = (32'(delta) < SLOTS) && (32'(off_reg) < SLOT_BYTES);

    // head byte address; head regs are stable from LOOK into EXEC
    assign rd_addr = ADDR_W'(head_slot_reg) * ADDR_W'(SLOT_BYTES) + ADDR_W'(head_offset_reg);
    assign pos_inc = {1'b0, head_offset_reg} + 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        window_base_next = window_base_reg;
        head_offset_next = head_offset_reg;
        head_slot_next   = head_slot_reg;
        filled_next      = filled_reg;
        res_status_next  = res_status_reg;
        res_byte_next    = res_byte_reg;
        res_rvalid_next  = res_rvalid_reg;
        res_pend_next    = res_pend_reg;
        len_we           = 1'b0;
        store_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next      = S_HLEN;
                res_status_next = ST_OK;
                res_byte_next   = '0;
                res_rvalid_next = 1'b0;
                res_pend_next   = 1'b0;
                if (op_reg == OP_WRITE)
                begin
                    if (!in_range_reg)
                    begin
                        res_status_next = ST_RANGE;
                    end
                    else if (filled_reg[slot_reg])
                    begin
                        res_status_next = ST_DUP;
                    end
                    else
                    begin
                        store_we = 1'b1;
                        if (eop_reg)
                        begin
                            len_we                = 1'b1;
                            filled_next[slot_reg] = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (!filled_reg[head_slot_reg])
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        res_byte_next   = store_q;
                        res_rvalid_next = 1'b1;
                        if (pos_inc >= len_q)
                        begin
                            // packet drained: free slot, slide window
                            res_pend_next              = 1'b1;
                            filled_next[head_slot_reg] = 1'b0;
                            head_offset_next           = '0;
                            head_slot_next   = (head_slot_reg == LAST_SLOT) ? '0
                                                                           : head_slot_reg + 1'b1;
                            window_base_next = window_base_reg + 1'b1;
                        end
                        else
                        begin
                            head_offset_next = pos_inc[OFF_W-1:0];
                        end
                    end
                end
            end
            S_HLEN:
            begin
                // len_q picks up the (possibly new) head slot this cycle
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_base_reg <= SEQ_W'(1);
            head_offset_reg <= '0;
            head_slot_reg   <= '0;
            filled_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                // restart; to be written only while idle, which the block itself does not enforce
                window_base_reg <= initial_sequence;
                head_offset_reg <= '0;
                head_slot_reg   <= '0;
                filled_reg      <= '0;
            end
            else
            begin
                window_base_reg <= window_base_next;
                head_offset_reg <= head_offset_next;
                head_slot_reg   <= head_slot_next;
                filled_reg      <= filled_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            op_reg  <= op;
            seq_reg <= seq;
            off_reg <= byte_offset;
            val_reg <= byte_value;
            eop_reg <= end_of_packet;
        end
        if (state_reg == S_LOOK)
        begin
            slot_reg     <= slot_calc;
            in_range_reg <= in_range_calc;
            wr_addr_reg  <= ADDR_W'(slot_calc) * ADDR_W'(SLOT_BYTES) + ADDR_W'(off_reg);
        end
        res_status_reg <= res_status_next;
        res_byte_reg   <= res_byte_next;
        res_rvalid_reg <= res_rvalid_next;
        res_pend_reg   <= res_pend_next;
        if (load_out)
        begin
            status_reg      <= res_status_reg;
            read_byte_reg   <= res_byte_reg;
            read_valid_reg  <= res_rvalid_reg;
            packet_end_reg  <= res_pend_reg;
            head_length_reg <= filled_reg[head_slot_reg] ? len_q : '0;
        end
    end

    // length memory: one write, one registered read at the head slot
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[slot_reg] <= {1'b0, off_reg} + 1'b1;
        end
        len_q <= len_mem[head_slot_reg];
    end

    // byte store: one write, one registered read at the head byte
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[wr_addr_reg] <= val_reg;
        end
        store_q <= store_mem[rd_addr];
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_byte   = read_byte_reg;
    assign read_valid  = read_valid_reg;
    assign packet_end  = packet_end_reg;
    assign head_length = head_length_reg;

endmodule

/* sv/prb_checker.sv */
// Port-level checks for the packet reorder buffer, bound to the top level.
module prb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input prb_pkg::status_t              status,
    input logic [prb_pkg::BYTE_W-1:0]    read_byte,
    input logic                          read_valid,
    input logic                          packet_end,
    input logic [prb_pkg::LEN_W-1:0]     head_length
);
    import prb_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_byte)
            && $stable(head_length))
        else $error("result changed while stalled");

    // no data byte or end mark without a delivered byte
    a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !read_valid |-> read_byte == '0 && !packet_end)
        else $error("data shown without read_valid");

    // delivered bytes carry ok status
    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> status == ST_OK)
        else $error("delivered byte with error status");

    // empty head reports zero length
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> head_length == '0 && !read_valid)
        else $error("empty read with nonzero head length");

endmodule

bind packet_reorder_buffer_unit prb_checker u_prb_checker (.*);

/* sim/tb_top.sv */
// Self-checking testbench for packet_reorder_buffer_unit: slot-model scoreboard plus traffic tasks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prb_pkg::*;

    typedef struct packed {
        status_t     st;
        logic [7:0]  data;
        logic        data_ok;
        logic        last;
        logic [10:0] hlen;
    } word_result_t;

    class reassembly_tracker #(int SLOT_CNT = 64, int SLOT_SIZE = 1024);
        bit [15:0]    base_seq;
        bit [9:0]     head_off;
        int unsigned  head_slot;
        bit           filled [SLOT_CNT];
        bit [10:0]    plen   [SLOT_CNT];
        bit [7:0]     bytes  [SLOT_CNT*SLOT_SIZE];
        bit           stored [SLOT_CNT*SLOT_SIZE];
        word_result_t pending [$];
        int           errors;

        function new();
            errors = 0;
            restart(16'd1);
        endfunction

        // Window reload: byte store and lengths survive, fill marks do not.
        function void restart(bit [15:0] first);
            base_seq  = first;
            head_off  = '0;
            head_slot = 0;
            foreach (filled[i])
                filled[i] = 1'b0;
        endfunction

        function int slot_of(bit [15:0] s);
            bit [15:0] delta;
            delta = s - base_seq;
            if (delta >= SLOT_CNT)
                return -1;
            return int'((head_slot + delta) % SLOT_CNT);
        endfunction

        // An end mark here would fill the slot while some lower byte was never stored.
        function bit end_leaves_hole(bit [15:0] s, bit [9:0] off);
            int sl;
            sl = slot_of(s);
            if (sl < 0 || filled[sl])
                return 1'b0;
            for (int k = 0; k < off; k++)
                if (!stored[sl*SLOT_SIZE + k])
                    return 1'b1;
            return 1'b0;
        endfunction

        function bit read_ok();
            return !filled[head_slot] || stored[head_slot*SLOT_SIZE + head_off];
        endfunction

        function bit drained();
            return pending.size() == 0;
        endfunction

        function void predict_word(logic o, bit [15:0] s, bit [9:0] off, bit [7:0] v, logic e);
            word_result_t r;
            int sl;
            int pos;
            r    = '0;
            r.st = ST_OK;
            if (o == OP_WRITE)
            begin
                sl = slot_of(s);
                if (sl < 0 || off >= SLOT_SIZE)
                    r.st = ST_RANGE;
                else if (filled[sl])
                    r.st = ST_DUP;
                else
                begin
                    bytes[sl*SLOT_SIZE + off]  = v;
                    stored[sl*SLOT_SIZE + off] = 1'b1;
                    if (e)
                    begin
                        plen[sl]   = 11'(off) + 11'd1;
                        filled[sl] = 1'b1;
                    end
                end
            end
            else
            begin
                if (!filled[head_slot])
                    r.st = ST_EMPTY;
                else
                begin
                    pos       = int'(head_off);
                    r.data    = bytes[head_slot*SLOT_SIZE + pos];
                    r.data_ok = 1'b1;
                    if (pos + 1 >= plen[head_slot])
                    begin
                        r.last            = 1'b1;
                        filled[head_slot] = 1'b0;
                        head_off          = '0;
                        head_slot         = (head_slot + 1) % SLOT_CNT;
                        base_seq          = base_seq + 16'd1;
                    end
                    else
                        head_off = 10'(pos + 1);
                end
            end
            r.hlen = filled[head_slot] ? plen[head_slot] : 11'd0;
            pending.push_back(r);
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            end
        endfunction

        function void check_result(status_t st, logic [7:0] data, logic data_ok, logic last,
                                   logic [10:0] hlen);
            word_result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got status %0h byte %0h",
                         $time, st, data);
                return;
            end
            want = pending.pop_front();
            compare_field("status", 32'(want.st), 32'(st));
            compare_field("read_byte", 32'(want.data), 32'(data));
            compare_field("read_valid", 32'(want.data_ok), 32'(data_ok));
            compare_field("packet_end", 32'(want.last), 32'(last));
            compare_field("head_length", 32'(want.hlen), 32'(hlen));
        endfunction
    endclass

    // ---------------------------------------------------------------- DUT ports
    logic                clk              = 1'b0;
    logic                rst_n            = 1'b0;
    logic                cfg_write        = 1'b0;
    logic [SEQ_W-1:0]    initial_sequence = '0;
    logic                in_valid         = 1'b0;
    logic                in_ready;
    logic                op               = OP_WRITE;
    logic [SEQ_W-1:0]    seq              = '0;
    logic [OFF_W-1:0]    byte_offset      = '0;
    logic [BYTE_W-1:0]   byte_value       = '0;
    logic                end_of_packet    = 1'b0;
    logic                out_valid;
    logic                out_ready        = 1'b0;
    status_t             status;
    logic [BYTE_W-1:0]   read_byte;
    logic                read_valid;
    logic                packet_end;
    logic [LEN_W-1:0]    head_length;

    // ---------------------------------------------------------------- test state
    reassembly_tracker   tracker;
    int                  send_idle_pct = 0;   // chance per cycle that the sender holds back
    int                  recv_idle_pct = 0;   // chance per cycle that out_ready drops
    int                  hold_req      = 0;   // bumped to ask for one long receiver stall
    int                  hold_seen     = 0;
    int                  hold_left     = 0;
    int                  words_sent    = 0;

    packet_reorder_buffer_unit #(
        .SLOTS      (64),
        .SLOT_BYTES (1024)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .initial_sequence (initial_sequence),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .seq              (seq),
        .byte_offset      (byte_offset),
        .byte_value       (byte_value),
        .end_of_packet    (end_of_packet),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .read_byte        (read_byte),
        .read_valid       (read_valid),
        .packet_end       (packet_end),
        .head_length      (head_length)
    );

    always #1 clk = ~clk;

    // Receiver: random back-pressure, plus a long stall on request so the
    // pipeline backs up and in_ready drops while words keep being offered.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result monitor: values seen here are the ones held before this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(status, read_byte, read_valid, packet_end, head_length);
    end

    // ---------------------------------------------------------------- sender
    // Leaves valid high after acceptance unless an idle cycle follows, so
    // valid never sees two updates in one edge.
    task automatic send_word(logic o, logic [15:0] s, logic [9:0] off, logic [7:0] v, logic e);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= o;
        seq           <= s;
        byte_offset   <= off;
        byte_value    <= v;
        end_of_packet <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.predict_word(o, s, off, v, e);
        words_sent++;
    endtask

    // Read words carry random junk in the write-only fields.
    task automatic send_read();
        send_word(OP_READ, 16'($urandom), 10'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // Drops an end mark that would fill a slot over never-stored bytes.
    task automatic send_write(logic [15:0] s, logic [9:0] off, logic [7:0] v, logic e);
        send_word(OP_WRITE, s, off, v, e && !tracker.end_leaves_hole(s, off));
    endtask

    // Sender goes quiet until every outstanding result is back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (!tracker.drained());
    endtask

    task automatic restart_window(logic [15:0] first);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_write        <= 1'b1;
        initial_sequence <= first;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.restart(first);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // Window base is 1 after reset. The last pair leaves a 1024-byte head with
    // holes; it is never read and the following restart clears it.
    task automatic directed_words();
        send_read();                                            // empty head
        send_word(OP_WRITE, 16'd65, 10'd0, 8'h00, 1'b0);        // one past the window
        send_word(OP_WRITE, 16'd0, 10'd0, 8'h00, 1'b0);         // just behind the window
        send_word(OP_WRITE, 16'd64, 10'd0, 8'hFF, 1'b1);        // last window slot, 1 byte
        send_word(OP_WRITE, 16'd64, 10'd0, 8'h00, 1'b1);        // duplicate
        send_word(OP_WRITE, 16'd2, 10'd1, 8'hAA, 1'b0);
        send_word(OP_WRITE, 16'd2, 10'd0, 8'h55, 1'b0);
        send_word(OP_WRITE, 16'd2, 10'd3, 8'h3C, 1'b0);         // stored past the end
        send_word(OP_WRITE, 16'd2, 10'd1, 8'hC3, 1'b1);         // overwrite, length 2
        send_word(OP_WRITE, 16'd1, 10'd0, 8'h00, 1'b1);         // head arrives last
        send_read();
        send_read();
        send_read();
        send_read();                                            // head is a hole now
        send_word(OP_WRITE, 16'd3, 10'd1023, 8'hFF, 1'b1);      // max length 1024
        send_word(OP_WRITE, 16'd3, 10'd1023, 8'h00, 1'b0);      // duplicate
    endtask

    // A few packets near the window head, arriving out of order with their
    // bytes shuffled, then a drain that is usually full and sometimes partial.
    // Packet lengths are trimmed so the burst stays near the remaining word budget.
    task automatic packet_burst(int room);
        int        npk;
        int        span    [4];
        int        plen_of [4];
        bit        whole   [4];
        int        order   [4];
        int        offs    [$];
        int        p, j, tmp, total, nread, pick, cap;
        bit [15:0] base;
        npk   = $urandom_range(1, 4);
        base  = tracker.base_seq;
        total = 0;
        cap   = room / (2 * npk) + 1;
        for (int i = 0; i < 4; i++)
        begin
            order[i] = i;
            span[i]  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 63)) : i;
            pick     = $urandom_range(0, 99);
            if (pick < 85)
                plen_of[i] = $urandom_range(1, 6);
            else if (pick < 98)
                plen_of[i] = $urandom_range(7, 40);
            else
                plen_of[i] = $urandom_range(41, 300);
            if (plen_of[i] > cap)
                plen_of[i] = cap;
            whole[i] = ($urandom_range(0, 9) != 0);
        end
        for (int i = npk - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int n = 0; n < npk; n++)
        begin
            p = order[n];
            offs.delete();
            for (int k = 0; k < plen_of[p] - 1; k++)
                offs.push_back(k);
            if ($urandom_range(0, 3) != 0)
                for (int k = offs.size() - 1; k > 0; k--)
                begin
                    j       = $urandom_range(0, k);
                    tmp     = offs[k];
                    offs[k] = offs[j];
                    offs[j] = tmp;
                end
            // stray byte beyond the final length: kept but never delivered
            if ($urandom_range(0, 6) == 0)
                offs.push_back(plen_of[p] + int'($urandom_range(0, 20)));
            foreach (offs[k])
                send_word(OP_WRITE, 16'(base + span[p]), 10'(offs[k]), 8'($urandom), 1'b0);
            if (whole[p])
            begin
                send_write(16'(base + span[p]), 10'(plen_of[p] - 1), 8'($urandom), 1'b1);
                total += plen_of[p];
            end
        end
        nread = ($urandom_range(0, 9) < 7) ? total + int'($urandom_range(0, 2))
                                           : int'($urandom_range(0, total));
        for (int k = 0; k < nread; k++)
        begin
            if (!tracker.read_ok())
                break;
            send_read();
        end
    endtask

    // Single stray word: far-off or edge sequence numbers, scattered bytes
    // inside the window, a poke at the head slot, or a lone read.
    task automatic noise_word();
        bit [15:0] base;
        base = tracker.base_seq;
        case ($urandom_range(0, 5))
            0: send_write(16'($urandom), 10'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
            1: send_write(base + 16'($urandom_range(0, 63)), 10'($urandom), 8'($urandom),
                          $urandom_range(0, 3) == 0);
            2: send_write(base + 16'(64 + $urandom_range(0, 3)), 10'($urandom), 8'($urandom),
                          1'($urandom));
            3: send_write(base - 16'($urandom_range(1, 4)), 10'($urandom), 8'($urandom),
                          1'($urandom));
            4: send_write(base, 10'd0, 8'($urandom), 1'b0);
            default:
                if (tracker.read_ok())
                    send_read();
        endcase
    endtask

    task automatic run_traffic(int n);
        int stop_at;
        stop_at = words_sent + n;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 7)
                packet_burst(stop_at - words_sent);
            else
                noise_word();
        end
    endtask

    // ---------------------------------------------------------------- sequence
    initial
    begin
        tracker = new();
        set_idling(15, 56);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();

        // window wraps through zero right away
        restart_window(16'hFFFF);
        run_traffic(220);

        // long receiver stall in mid-traffic: block fills and pushes back
        restart_window(16'h0000);
        run_traffic(60);
        hold_req <= hold_req + 1;
        run_traffic(160);

        set_idling(56, 15);
        restart_window(16'($urandom));
        run_traffic(100);
        wait_drained();
        run_traffic(120);

        restart_window(16'hFFC8);
        run_traffic(220);

        // no idling at all, another long stall in the middle
        set_idling(0, 0);
        restart_window(16'($urandom));
        run_traffic(110);
        hold_req <= hold_req + 1;
        run_traffic(110);

        wait_drained();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
